@@ hdl/dsi_pkg.sv @@
// shared types and constants for the drive safety interlock
`default_nettype none

package dsi_pkg;

	// field widths of one request
	localparam int unsigned POS_W    = 16;
	localparam int unsigned SWITCH_W = 2;
	localparam int unsigned MASK_W   = 4;
	localparam int unsigned EVENT_W  = 7;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned POS_FIELDS = 4;

	// a switch counts as on only in this position
	localparam logic [SWITCH_W-1:0] SWITCH_ON = 2'd2;

	// event bit positions
	localparam int unsigned EV_ESTOP   = 0;
	localparam int unsigned EV_ENABLED = 1;
	localparam int unsigned EV_CAPTURE = 2;
	localparam int unsigned EV_HOLD    = 3;
	localparam int unsigned EV_RELAX   = 4;
	localparam int unsigned EV_RUN     = 5;
	localparam int unsigned EV_OFF     = 6;

	// input request, last field in the lowest bits
	typedef struct packed {
		logic signed [POS_W-1:0]  position_three;
		logic signed [POS_W-1:0]  position_two;
		logic signed [POS_W-1:0]  position_one;
		logic signed [POS_W-1:0]  position_zero;
		logic [MASK_W-1:0]        online_mask;
		logic [SWITCH_W-1:0]      drive_switch;
		logic [SWITCH_W-1:0]      hold_switch;
		logic [SWITCH_W-1:0]      enable_switch;
		logic                     fault_flag;
		logic                     link_connected;
	} in_item_t;

	// result request, last field in the lowest bits
	typedef struct packed {
		logic signed [POS_W-1:0]  ref_three;
		logic signed [POS_W-1:0]  ref_two;
		logic signed [POS_W-1:0]  ref_one;
		logic signed [POS_W-1:0]  ref_zero;
		logic [MASK_W-1:0]        captured_mask;
		logic                     drive_active;
		logic                     hold_active;
		logic                     estop_flag;
		logic                     output_allowed;
		logic [EVENT_W-1:0]       event_bits;
		logic [MODE_W-1:0]        system_mode;
	} out_item_t;

	localparam int unsigned IN_ITEM_W  = $bits(in_item_t);
	localparam int unsigned OUT_ITEM_W = $bits(out_item_t);
	localparam int unsigned S_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W  = ((OUT_ITEM_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ hdl/drive_safety_interlock_fsm_unit.sv @@
// Drive safety interlock: update register, mode logic and result register.
//
// Slave stream s_axis carries one status update per request; master stream
// m_axis returns exactly one result per update, in order. cfg_we writes the
// required-joint mask from cfg_wdata; write it only while no update is in
// flight.
// An accepted update sits in the update register; then the mode, hold, run
// and capture logic lands in the result register together with the new
// state, and m_axis_tvalid rises. One update per cycle is sustained while
// m_axis_tready stays high; the update register and the result register form
// a two-deep pipeline, so a new update is taken while a finished result waits.
// When the receiver holds m_axis_tready low the result register holds its
// request, the update register fills, and s_axis_tready then drops until the
// result is taken.
// Reset (arst_n low) empties both stages, sets the mode to disabled, clears
// hold, run, the captured mask and all hold references, and loads the
// required-joint mask with all joints.
`default_nettype none

module drive_safety_interlock_fsm_unit #(
	parameter int unsigned JOINT_COUNT    = 4,
	parameter int unsigned POSITION_WIDTH = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// required joint mask write
	input  wire                                 cfg_we,
	input  wire  [dsi_pkg::MASK_W-1:0]          cfg_wdata,
	// status update in
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// link_connected, fault_flag, enable_switch, hold_switch, drive_switch,
	// online_mask, position_zero, position_one, position_two, position_three
	input  wire  [dsi_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	// result out
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// system_mode, event_bits, output_allowed, estop_flag, hold_active,
	// drive_active, captured_mask, ref_zero, ref_one, ref_two, ref_three
	output logic [dsi_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
	import dsi_pkg::*;

	localparam int unsigned REF_N = (JOINT_COUNT < POS_FIELDS) ? JOINT_COUNT : POS_FIELDS;
	localparam int unsigned EXT_W = (POSITION_WIDTH > POS_W) ? POSITION_WIDTH : POS_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_DISABLED = 2'd0,
		MODE_ENABLED  = 2'd1,
		MODE_ESTOP    = 2'd2
	} mode_t;

	// pipeline stages
	logic      in_valid_s1;
	in_item_t  in_s1;
	logic      out_valid_q;
	out_item_t out_q;
	logic      adv;

	// supervisor state
	mode_t                     mode_q;
	logic                      hold_q;
	logic                      run_q;
	logic [MASK_W-1:0]         req_mask_q;
	logic [MASK_W-1:0]         valid_mask_q;
	logic [POSITION_WIDTH-1:0] ref_q [REF_N];

	// next-state signals
	mode_t                     mode_n;
	logic [EVENT_W-1:0]        ev_n;
	logic                      capture;
	logic                      en_on;
	logic                      hold_n;
	logic                      run_n;
	logic [MASK_W-1:0]         valid_mask_n;
	logic [MASK_W-1:0]         online_req;
	logic [POS_W-1:0]          pos    [POS_FIELDS];
	logic [POS_W-1:0]          ref_out[POS_FIELDS];
	out_item_t                 out_n;

	// handshake: update stage moves on when the result register is free or its result is taken
	assign adv           = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W - OUT_ITEM_W){1'b0}}, out_q};

	// update register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_s1 <= in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
		end
	end

	// positions as an array
	assign pos[0] = in_s1.position_zero;
	assign pos[1] = in_s1.position_one;
	assign pos[2] = in_s1.position_two;
	assign pos[3] = in_s1.position_three;

	assign online_req = in_s1.online_mask & req_mask_q;

	// mode transition and events
	always_comb begin
		en_on        = (in_s1.enable_switch == SWITCH_ON);
		mode_n       = mode_q;
		ev_n         = '0;
		capture      = 1'b0;
		valid_mask_n = valid_mask_q;
		if (!in_s1.link_connected || in_s1.fault_flag) begin
			if (mode_q != MODE_ESTOP) begin
				ev_n[EV_ESTOP] = 1'b1;
			end
			mode_n = MODE_ESTOP;
		end else if (en_on) begin
			if (mode_q != MODE_ENABLED) begin
				if (online_req == req_mask_q) begin
					capture            = 1'b1;
					valid_mask_n       = online_req;
					ev_n[EV_ENABLED]   = 1'b1;
					ev_n[EV_CAPTURE]   = 1'b1;
					mode_n             = MODE_ENABLED;
				end else begin
					mode_n = MODE_DISABLED;
				end
			end
		end else begin
			if (mode_q == MODE_ENABLED) begin
				mode_n         = MODE_ESTOP;
				ev_n[EV_ESTOP] = 1'b1;
			end else if (mode_q != MODE_ESTOP) begin
				mode_n = MODE_DISABLED;
			end
		end

		// hold and run follow their switches only while enabled
		hold_n = (mode_n == MODE_ENABLED) && (in_s1.hold_switch == SWITCH_ON);
		run_n  = (mode_n == MODE_ENABLED) && (in_s1.drive_switch == SWITCH_ON);
		if (hold_n != hold_q) begin
			ev_n[EV_HOLD]  = hold_n;
			ev_n[EV_RELAX] = !hold_n;
		end
		if (run_n != run_q) begin
			ev_n[EV_RUN] = run_n;
			ev_n[EV_OFF] = !run_n;
		end
	end

	// hold references, one register per stored joint
	for (genvar i = 0; i < POS_FIELDS; i++) begin : g_ref
		if (i < REF_N) begin : g_store
			logic [POSITION_WIDTH-1:0] ref_n;
			assign ref_n      = capture ? POSITION_WIDTH'(EXT_W'(pos[i])) : ref_q[i];
			assign ref_out[i] = POS_W'(EXT_W'(ref_n));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ref_q[i] <= '0;
				end else if (adv) begin
					ref_q[i] <= ref_n;
				end
			end
		end else begin : g_none
			assign ref_out[i] = '0;
		end
	end

	// result assembly
	always_comb begin
		out_n                = '0;
		out_n.system_mode    = mode_n;
		out_n.event_bits     = ev_n;
		out_n.output_allowed = (mode_n == MODE_ENABLED);
		out_n.estop_flag     = (mode_n == MODE_ESTOP);
		out_n.hold_active    = hold_n;
		out_n.drive_active   = run_n;
		out_n.captured_mask  = valid_mask_n;
		out_n.ref_zero       = ref_out[0];
		out_n.ref_one        = ref_out[1];
		out_n.ref_two        = ref_out[2];
		out_n.ref_three      = ref_out[3];
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_DISABLED;
			hold_q       <= 1'b0;
			run_q        <= 1'b0;
			valid_mask_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				mode_q       <= mode_n;
				hold_q       <= hold_n;
				run_q        <= run_n;
				valid_mask_q <= valid_mask_n;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= out_n;
		end
	end

	// required joint mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_mask_q <= '1;
		end else if (cfg_we) begin
			req_mask_q <= cfg_wdata;
		end
	end

	// hold and run are only ever on while enabled
	a_hold_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q || run_q) |-> (mode_q == MODE_ENABLED))
		else $error("hold or run active outside enabled mode");

	// an estop event is only raised when leaving another mode
	a_estop_event_once: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ev_n[EV_ESTOP]) |-> (mode_q != MODE_ESTOP && mode_n == MODE_ESTOP))
		else $error("estop event without entering estop");

	// a capture records the online required joints
	a_capture_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && capture) |=> (valid_mask_q == $past(online_req) && mode_q == MODE_ENABLED))
		else $error("captured mask does not match required online joints");

	// a stalled result never loses the pending update
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready && in_valid_s1) |=> in_valid_s1)
		else $error("pending update dropped while result stalled");

endmodule

`default_nettype wire
